// ===== rtl/core/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// types, result codes and the character map of the base64 stream decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned SymWidth   = 6;
  localparam int unsigned GroupWidth = 3 * SymWidth;
  localparam int unsigned MaxResults = 4;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic                 ok;
    logic                 pad;
    logic [SymWidth-1:0]  val;
  } sym_t;

  typedef struct packed {
    logic [ByteWidth-1:0] data;
    kind_t                kind;
  } result_t;

  // a batch of results caused by one input transaction
  typedef struct packed {
    logic [2:0]               count;
    result_t [MaxResults-1:0] res;
  } batch_t;

  function automatic sym_t map_symbol(input logic [CharWidth-1:0] ch);
    sym_t s;
    s = '{ok: 1'b1, pad: 1'b0, val: '0};
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      s.val = SymWidth'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      s.val = SymWidth'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s.val = SymWidth'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B) begin
      s.val = SymWidth'(62);
    end else if (ch == 8'h2F) begin
      s.val = SymWidth'(63);
    end else if (ch == 8'h3D) begin
      s.pad = 1'b1;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/b64d_group.sv =====
// ----------------------------------------------------------------------------
// b64d_group
// collects 6-bit symbols into groups and builds the result batch of each
// character in one pass, registered into a batch register
// ----------------------------------------------------------------------------
module b64d_group
  import b64d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CharWidth-1:0] in_char,
  input  logic                 in_end,
  output logic                 batch_valid,
  input  logic                 batch_take,
  output batch_t               batch
);

  logic [GroupWidth-1:0] group_bits, group_bits_next;
  logic [1:0]            group_count, group_count_next;
  logic [1:0]            pad_count, pad_count_next;
  logic                  error_seen, error_seen_next;
  batch_t                batch_next;
  sym_t                  sym;
  logic [GroupWidth+SymWidth-1:0] full;
  logic [2:0]            pads;
  logic [2:0]            n;
  logic                  accept;

  assign in_ready = !batch_valid || batch_take;
  assign accept   = in_valid && in_ready;
  assign sym      = map_symbol(in_char);
  assign full     = {group_bits, sym.val};
  assign pads     = 3'(pad_count) + 3'(sym.pad);

  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    pad_count_next   = pad_count;
    error_seen_next  = error_seen;
    batch_next       = '0;
    n                = '0;
    if (!error_seen) begin
      if (!sym.ok) begin
        batch_next.res[0] = '{data: '0, kind: KIND_ERROR};
        n                 = 3'd1;
        error_seen_next   = 1'b1;
      end else if (group_count != 2'd3) begin
        group_bits_next  = {group_bits[GroupWidth-SymWidth-1:0], sym.val};
        group_count_next = group_count + 2'd1;
        pad_count_next   = pad_count + 2'(sym.pad);
      end else begin
        // group complete: keep the leading 3 - pads bytes
        batch_next.res[0] = '{data: full[23:16], kind: KIND_BYTE};
        batch_next.res[1] = '{data: full[15:8],  kind: KIND_BYTE};
        batch_next.res[2] = '{data: full[7:0],   kind: KIND_BYTE};
        n                 = (pads >= 3'd3) ? 3'd0 : 3'd3 - pads;
        group_bits_next   = '0;
        group_count_next  = '0;
        pad_count_next    = '0;
      end
    end
    if (in_end) begin
      if (!error_seen_next) begin
        batch_next.res[n[1:0]] = '{data: '0, kind: KIND_END};
        n                      = n + 3'd1;
      end
      group_bits_next  = '0;
      group_count_next = '0;
      pad_count_next   = '0;
      error_seen_next  = 1'b0;
    end
    batch_next.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits  <= '0;
      group_count <= '0;
      pad_count   <= '0;
      error_seen  <= 1'b0;
      batch_valid <= 1'b0;
    end else begin
      if (accept) begin
        group_bits  <= group_bits_next;
        group_count <= group_count_next;
        pad_count   <= pad_count_next;
        error_seen  <= error_seen_next;
        batch_valid <= (n != 3'd0);
      end else if (batch_take) begin
        batch_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      batch <= batch_next;
    end
  end

endmodule

// ===== rtl/core/b64d_serial.sv =====
// ----------------------------------------------------------------------------
// b64d_serial
// holds one result batch and sends its results one transaction per cycle while out_ready is high
// ----------------------------------------------------------------------------
module b64d_serial
  import b64d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 batch_valid,
  output logic                 batch_take,
  input  batch_t               batch,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ByteWidth-1:0] out_data,
  output kind_t                out_kind,
  output logic                 out_last
);

  batch_t     cur;
  logic [1:0] idx;
  logic       done;

  assign out_last   = ({1'b0, idx} == cur.count - 3'd1);
  assign done       = out_valid && out_ready && out_last;
  assign batch_take = batch_valid && (!out_valid || done);
  assign out_data   = cur.res[idx].data;
  assign out_kind   = cur.res[idx].kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (batch_take) begin
        out_valid <= 1'b1;
        idx       <= '0;
      end else if (done) begin
        out_valid <= 1'b0;
        idx       <= '0;
      end else if (out_valid && out_ready) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (batch_take) begin
      cur <= batch;
    end
  end

endmodule

// ===== rtl/core/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// one base64 character in per transaction, decoded bytes and status out
// ----------------------------------------------------------------------------
// path: the results of a character pass the batch register, then the output stage
// throughput: one character per cycle while the output keeps up and no batch
//   holds more than one result; each character gives zero to four results,
//   sent one per cycle, while ready, from a batch register and an output stage
// reset: synchronous, clears the group, padding and error state and all valids
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  logic       s_axis_tlast,   // text_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] byte_out
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast    // run_last
);

  logic   batch_valid;
  logic   batch_take;
  batch_t batch;
  kind_t  out_kind;

  b64d_group u_group (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_char     (s_axis_tdata),
    .in_end      (s_axis_tlast),
    .batch_valid (batch_valid),
    .batch_take  (batch_take),
    .batch       (batch)
  );

  b64d_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .batch_valid (batch_valid),
    .batch_take  (batch_take),
    .batch       (batch),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .out_kind    (out_kind),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;

endmodule
